/* rtl/wlrs_pkg.sv */
// shared types and constants for the weighted longest run scorer
package wlrs_pkg;

  localparam int ROW_W    = 16;
  localparam int WEIGHT_W = 11;
  localparam int SCORE_W  = 15;

  // largest score, the sum saturates here
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // columns folded by one adder in the first tree level
  localparam int GROUP_SIZE = 8;

  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [SCORE_W-1:0]  score_t;

endpackage

/* rtl/wlrs_if.sv */
// valid/ready channel interfaces for row requests and score requests
interface wlrs_in_if;
  logic             valid;
  logic             ready;
  wlrs_pkg::row_t    row_bits;
  wlrs_pkg::weight_t row_weight;
  logic             row_last;

  modport source (output valid, row_bits, row_weight, row_last, input ready);
  modport sink   (input valid, row_bits, row_weight, row_last, output ready);
endinterface

interface wlrs_out_if;
  logic             valid;
  logic             ready;
  wlrs_pkg::score_t score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface

/* rtl/wlrs_col.sv */
// per-column run tracker: current weighted run and best run so far
module wlrs_col #(
  parameter int RUN_W    = 11,
  parameter int MAX_ROWS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 row_bit,
  input  wlrs_pkg::weight_t    row_weight,
  input  logic                 row_last,
  output logic [RUN_W-1:0]     best_upd
);

  localparam int SUM_W = ((RUN_W > wlrs_pkg::WEIGHT_W) ? RUN_W : wlrs_pkg::WEIGHT_W) + 1;

  logic [RUN_W-1:0] run_r, run_nxt;
  logic [RUN_W-1:0] best_r, best_nxt;
  logic [SUM_W-1:0] ext_sum;
  logic [RUN_W-1:0] run_sat;

  // extend the run, saturating at the row limit
  assign ext_sum = SUM_W'(run_r) + SUM_W'(row_weight);
  assign run_sat = (ext_sum > SUM_W'(MAX_ROWS)) ? RUN_W'(MAX_ROWS) : RUN_W'(ext_sum);

  // a zero bit ends the run, a one may raise the best
  always_comb begin
    run_nxt  = row_bit ? run_sat : '0;
    best_nxt = (row_bit && (run_sat > best_r)) ? run_sat : best_r;
  end

  assign best_upd = best_nxt;

  // state clears after the last row of an ordering
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      best_r <= '0;
    end else if (accept) begin
      if (row_last) begin
        run_r  <= '0;
        best_r <= '0;
      end else begin
        run_r  <= run_nxt;
        best_r <= best_nxt;
      end
    end
  end

endmodule

/* rtl/wlrs_sum.sv */
// score pipeline: snapshot of best runs, registered group sums, saturated total
module wlrs_sum #(
  parameter int NCOLUMNS = 16,
  parameter int RUN_W    = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  output logic                              take_ready,
  input  logic [NCOLUMNS-1:0][RUN_W-1:0]    best_in,
  wlrs_out_if.source                        out_ch
);

  localparam int GSZ    = wlrs_pkg::GROUP_SIZE;
  localparam int GROUPS = (NCOLUMNS + GSZ - 1) / GSZ;
  localparam int PAD_N  = GROUPS * GSZ;
  localparam int GRP_W  = RUN_W + $clog2(GSZ);
  localparam int TOT_W  = GRP_W + $clog2(GROUPS);
  localparam int CMP_W  = (TOT_W > wlrs_pkg::SCORE_W) ? TOT_W : wlrs_pkg::SCORE_W;

  logic                          snap_v_r;
  logic [PAD_N-1:0][RUN_W-1:0]   snap_r;
  logic                          grp_v_r;
  logic [GROUPS-1:0][GRP_W-1:0]  grp_r, grp_nxt;
  logic                          out_v_r;
  wlrs_pkg::score_t              score_r, score_nxt;
  logic [TOT_W-1:0]              total;
  logic                          out_adv, grp_free, snap_free;

  // each stage moves on when the one after it is empty or moving
  assign out_adv    = !out_v_r || out_ch.ready;
  assign grp_free   = !grp_v_r || out_adv;
  assign snap_free  = !snap_v_r || grp_free;
  assign take_ready = snap_free;

  // first tree level: one sum per group of columns
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GSZ; k++) begin
        grp_nxt[g] = grp_nxt[g] + GRP_W'(snap_r[g*GSZ+k]);
      end
    end
  end

  // second level: total over groups, clipped to the score range
  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + TOT_W'(grp_r[g]);
    end
    score_nxt = (CMP_W'(total) > CMP_W'(wlrs_pkg::SCORE_MAX)) ?
                wlrs_pkg::SCORE_MAX : wlrs_pkg::score_t'(CMP_W'(total));
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
      grp_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (snap_free) snap_v_r <= take;
      if (grp_free)  grp_v_r  <= snap_v_r;
      if (out_adv)   out_v_r  <= grp_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (snap_free && take) begin
      for (int c = 0; c < PAD_N; c++) begin
        snap_r[c] <= (c < NCOLUMNS) ? best_in[c] : '0;
      end
    end
    if (grp_free && snap_v_r) grp_r   <= grp_nxt;
    if (out_adv && grp_v_r)   score_r <= score_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.score = score_r;

endmodule

/* rtl/weighted_longest_run_score_top.sv */
// top level of the weighted longest run scorer
//
// Scores one row ordering of a 0/1 membership matrix. Rows come in on
// in_ch, one request per row: row_bits holds one bit per column,
// row_weight the row's multiplicity and row_last marks the final row.
// Each column keeps its current weighted run of ones (saturating at
// MAX_ROWS) and its best run. After the last row the sum of the best runs,
// clipped to 32767, leaves on out_ch as one score request; rows that are
// not last give no result.
// Throughput: one row per cycle while in_ch.ready is high, set by the
// per-column add and compare. After the edge that takes the last row, the
// score passes the snapshot, group sum and output registers to out_ch.
// Column state clears on that same edge, so the next ordering may start
// in the following cycle.
// Reset (rst_n low, synchronous) clears all runs and empties the pipeline.
// When the receiver stalls the score holds; up to three scores queue in the
// pipeline, and only when all three stages are full does in_ch.ready drop.
module weighted_longest_run_score_top #(
  parameter int NCOLUMNS = 16,
  parameter int MAX_ROWS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  wlrs_in_if.sink      in_ch,
  wlrs_out_if.source   out_ch
);

  localparam int RUN_W = $clog2(MAX_ROWS + 1);

  logic                           accept;
  logic                           take_ready;
  logic [NCOLUMNS-1:0][RUN_W-1:0] best_upd;

  // a row request is taken whenever the snapshot stage can take a score
  assign in_ch.ready = take_ready;
  assign accept      = in_ch.valid && take_ready;

  // one run tracker per column; columns beyond the row width see zeros
  for (genvar c = 0; c < NCOLUMNS; c++) begin : g_col
    logic col_bit;
    if (c < wlrs_pkg::ROW_W) begin : g_in
      assign col_bit = in_ch.row_bits[c];
    end else begin : g_zero
      assign col_bit = 1'b0;
    end

    wlrs_col #(
      .RUN_W    (RUN_W),
      .MAX_ROWS (MAX_ROWS)
    ) u_col (
      .clk        (clk),
      .rst_n      (rst_n),
      .accept     (accept),
      .row_bit    (col_bit),
      .row_weight (in_ch.row_weight),
      .row_last   (in_ch.row_last),
      .best_upd   (best_upd[c])
    );
  end

  // score pipeline
  wlrs_sum #(
    .NCOLUMNS (NCOLUMNS),
    .RUN_W    (RUN_W)
  ) u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (accept && in_ch.row_last),
    .take_ready (take_ready),
    .best_in    (best_upd),
    .out_ch     (out_ch)
  );

endmodule

/* rtl/wlrs_checker.sv */
// port-level checks for the weighted longest run scorer, bound to the top
module wlrs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input wlrs_pkg::score_t out_score
);

  // reset empties the score pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("score request valid after reset");

  // rows are only refused when a stalled score backs up the pipeline
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("row request refused while output not stalled");

  // a stalled score request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_score)))
    else $error("stalled score request changed or dropped");

endmodule

bind weighted_longest_run_score_top wlrs_checker u_wlrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_score (out_ch.score)
);

/* dv/testbench.sv */
// self-checking testbench for the weighted longest run scorer
`timescale 1ns / 100ps

module testbench;

  localparam int NCOLUMNS     = 16;
  localparam int MAX_ROWS     = 1024;
  localparam int RANDOM_ROWS  = 1050;
  localparam int BURST_ROWS   = 30;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // one directed row; when known is set the score is typed in, else predicted
  typedef struct packed {
    wlrs_pkg::row_t    bits;
    wlrs_pkg::weight_t weight;
    logic              last;
    logic              known;
    wlrs_pkg::score_t  score;
  } row_vec_t;

  localparam int NUM_DIRECTED = 22;
  localparam row_vec_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // single all-ones row right after reset
    '{16'hFFFF, 11'd1,    1'b1, 1'b1, 15'd16},
    // empty row scores nothing
    '{16'h0000, 11'd1024, 1'b1, 1'b1, 15'd0},
    // largest in-range weight on every column
    '{16'hFFFF, 11'd1024, 1'b1, 1'b1, 15'd16384},
    // two full-weight rows, runs saturate
    '{16'hFFFF, 11'd1024, 1'b0, 1'b0, 15'd0},
    '{16'hFFFF, 11'd1024, 1'b1, 1'b1, 15'd16384},
    // zero weight extends by nothing
    '{16'hFFFF, 11'd0,    1'b1, 1'b1, 15'd0},
    // weights above range clip at the run limit
    '{16'h0001, 11'd2047, 1'b1, 1'b1, 15'd1024},
    '{16'h8000, 11'd1025, 1'b1, 1'b1, 15'd1024},
    // a zero bit breaks the run, best run is kept
    '{16'h0001, 11'd5,    1'b0, 1'b0, 15'd0},
    '{16'h0000, 11'd7,    1'b0, 1'b0, 15'd0},
    '{16'h0001, 11'd3,    1'b1, 1'b0, 15'd0},
    // alternating columns
    '{16'hAAAA, 11'd1,    1'b0, 1'b0, 15'd0},
    '{16'h5555, 11'd1,    1'b0, 1'b0, 15'd0},
    '{16'hFFFF, 11'd2,    1'b1, 1'b0, 15'd0},
    // halves then all
    '{16'h00FF, 11'd512,  1'b0, 1'b0, 15'd0},
    '{16'hFF00, 11'd512,  1'b0, 1'b0, 15'd0},
    '{16'hFFFF, 11'd512,  1'b1, 1'b0, 15'd0},
    // zero row in the middle, ending on an empty last row
    '{16'h1234, 11'd100,  1'b0, 1'b0, 15'd0},
    '{16'h0000, 11'd0,    1'b0, 1'b0, 15'd0},
    '{16'h0000, 11'd1,    1'b1, 1'b0, 15'd0},
    // run reaching the limit exactly
    '{16'h7FFF, 11'd1023, 1'b0, 1'b0, 15'd0},
    '{16'h7FFF, 11'd1,    1'b1, 1'b0, 15'd0}
  };

  logic clk;
  logic rst_n;

  wlrs_in_if  in_ch ();
  wlrs_out_if out_ch ();

  weighted_longest_run_score_top #(
    .NCOLUMNS(NCOLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // column state of the predictor
  int col_run  [NCOLUMNS];
  int col_best [NCOLUMNS];

  wlrs_pkg::score_t pending_scores [$];
  int               score_errors;
  int               rows_sent;
  bit               src_quiet;
  bit               snk_quiet;
  bit               hold_scores;
  bit               hold_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // applies one row to the column state; returns 1 with the score on a last row
  function automatic bit apply_row(input wlrs_pkg::row_t bits, input wlrs_pkg::weight_t weight,
                                   input logic last, output wlrs_pkg::score_t score);
    int c;
    int r;
    int sum;
    sum = 0;
    score = '0;
    for (c = 0; c < NCOLUMNS; c++) begin
      if (c < wlrs_pkg::ROW_W && bits[c]) begin
        r = col_run[c] + int'(weight);
        if (r > MAX_ROWS) r = MAX_ROWS;
        col_run[c] = r;
        if (r > col_best[c]) col_best[c] = r;
      end else begin
        col_run[c] = 0;
      end
    end
    if (!last) return 1'b0;
    for (c = 0; c < NCOLUMNS; c++) begin
      sum += col_best[c];
      if (sum > int'(wlrs_pkg::SCORE_MAX)) sum = int'(wlrs_pkg::SCORE_MAX);
    end
    score = wlrs_pkg::score_t'(sum);
    for (c = 0; c < NCOLUMNS; c++) begin
      col_run[c]  = 0;
      col_best[c] = 0;
    end
    return 1'b1;
  endfunction

  // offers one row request and records the score it is due to produce
  task automatic offer_row(input wlrs_pkg::row_t bits, input wlrs_pkg::weight_t weight,
                           input logic last, input logic known,
                           input wlrs_pkg::score_t known_score);
    int               gap;
    bit               scored;
    wlrs_pkg::score_t predicted;
    gap = src_quiet ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.row_bits   <= bits;
    in_ch.row_weight <= weight;
    in_ch.row_last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scored = apply_row(bits, weight, last, predicted);
    if (known) predicted = known_score;
    if (scored) pending_scores = {pending_scores, predicted};
    rows_sent++;
  endtask

  // one ordering of random rows; heavy orderings push runs to saturation
  task automatic random_ordering(input int rows, input bit heavy);
    int                i;
    int                pick;
    wlrs_pkg::row_t    bits;
    wlrs_pkg::weight_t weight;
    for (i = 0; i < rows; i++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0, 1: begin
          bits = wlrs_pkg::row_t'($urandom);
        end
        2: begin
          bits = wlrs_pkg::row_t'($urandom) | wlrs_pkg::row_t'($urandom);
        end
        3: begin
          bits = wlrs_pkg::row_t'($urandom) & wlrs_pkg::row_t'($urandom);
        end
        4: begin
          bits = '1;
        end
        default: begin
          bits = ~(wlrs_pkg::row_t'(1) << $urandom_range(0, wlrs_pkg::ROW_W - 1));
        end
      endcase
      if (heavy) begin
        weight = wlrs_pkg::weight_t'($urandom_range(256, 1024));
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) weight = '0;
        else if (pick == 1) weight = wlrs_pkg::weight_t'($urandom_range(1025, 2047));
        else if (pick == 2) weight = wlrs_pkg::weight_t'(1024);
        else if (pick < 10) weight = wlrs_pkg::weight_t'($urandom_range(1, 16));
        else weight = wlrs_pkg::weight_t'($urandom_range(1, 1024));
      end
      offer_row(bits, weight, i == rows - 1, 1'b0, '0);
    end
  endtask

  // row source and end of run
  initial begin : row_source
    int     k;
    int     pick;
    int     random_start;
    in_ch.valid      <= 1'b0;
    in_ch.row_bits   <= '0;
    in_ch.row_weight <= '0;
    in_ch.row_last   <= 1'b0;
    rst_n            <= 1'b0;
    score_errors = 0;
    rows_sent    = 0;
    src_quiet    = 1'b0;
    snk_quiet    = 1'b0;
    hold_scores  = 1'b0;
    hold_done    = 1'b0;
    for (k = 0; k < NCOLUMNS; k++) begin
      col_run[k]  = 0;
      col_best[k] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (k = 0; k < NUM_DIRECTED; k++) begin
      offer_row(DIRECTED_ROWS[k].bits, DIRECTED_ROWS[k].weight, DIRECTED_ROWS[k].last,
                DIRECTED_ROWS[k].known, DIRECTED_ROWS[k].score);
    end

    // random orderings, with a pause and a receiver hold-off midway
    random_start = rows_sent;
    while (rows_sent - random_start < RANDOM_ROWS) begin
      if (rows_sent - random_start >= RANDOM_ROWS / 2 && !hold_done) begin
        // stop sending and let every score drain, then flood a held receiver
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0) @(posedge clk);
        hold_done   = 1'b1;
        hold_scores = 1'b1;
        for (k = 0; k < BURST_ROWS; k++) begin
          src_quiet = 1'b1;
          random_ordering(1, 1'b0);
        end
        src_quiet = 1'b0;
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) random_ordering($urandom_range(1, 6), 1'b0);
      else if (pick < 19) random_ordering($urandom_range(7, 30), 1'b0);
      else random_ordering($urandom_range(31, 60), 1'b1);
    end
    in_ch.valid <= 1'b0;

    // drain the pipeline
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (score_errors == 0 && pending_scores.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // score sink with random back-pressure and one long hold-off
  initial begin : score_sink
    int               gap;
    wlrs_pkg::score_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_scores) begin
        gap = LONG_HOLD;
        hold_scores = 1'b0;
      end else begin
        gap = snk_quiet ? 0 : $urandom_range(0, 19);
      end
      if ($urandom_range(0, 39) == 0) snk_quiet = !snk_quiet;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_scores.size() == 0) begin
        score_errors++;
        if (score_errors <= MAX_REPORTS)
          $display("%0t: unexpected score request %0d", $realtime, out_ch.score);
      end else begin
        want = pending_scores.pop_front();
        if (out_ch.score !== want) begin
          score_errors++;
          if (score_errors <= MAX_REPORTS)
            $display("%0t: score mismatch, expected %0d, actual %0d", $realtime, want,
                     out_ch.score);
        end
      end
    end
  end

  // watchdog on cycles with no accepted request on either channel
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d scores outstanding", idle_cycles,
               pending_scores.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
